@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition checked at every clock edge outside reset.
`define TRO_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TRO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tro_pkg.sv @@
`timescale 1ns / 1ps

package tro_pkg;

  localparam int HARD_DIMS = 4;
  localparam int SIZE_W    = 8;
  localparam int HOPS_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_COUNT = 3'd0,
    REG_SIZE_DIM0 = 3'd1,
    REG_SIZE_DIM1 = 3'd2,
    REG_SIZE_DIM2 = 3'd3,
    REG_SIZE_DIM3 = 3'd4
  } reg_idx_t;

endpackage

@@ rtl/torus_relative_offset_top.sv @@
`timescale 1ns / 1ps

// Torus relative offset. Splits a source and a destination node id into
// mixed-radix coordinates using the configured per-dimension sizes and
// reports the minimal hop count and a west (negative) flag per dimension;
// dimensions beyond dimension_count read zero, and a size of zero acts as one.
// Fully pipelined: one transaction per cycle is accepted and delivered while
// the output is not stalled by m_tready. Each coordinate comes from a
// restoring divider that retires one quotient bit per stage, followed by a
// wrap stage and the output register. Write the size and count registers
// only while the pipeline is empty.

`include "assert_macros.svh"

module torus_relative_offset_top import tro_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [SIZE_W-1:0]                 cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // fields from bit 0: source_node, dest_node
  input  logic [((2*NODE_ID_BITS+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // fields from bit 0: hops_dim0, west_dim0, hops_dim1, west_dim1,
  // hops_dim2, west_dim2, hops_dim3, west_dim3
  output logic [HARD_DIMS*(HOPS_W+1)-1:0]  m_tdata
);

  localparam int N  = NODE_ID_BITS;
  localparam int NS = MAX_DIMS * NODE_ID_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIMS);

  typedef struct packed {
    logic [N-1:0]                   sx;
    logic [N-1:0]                   dx;
    logic [SIZE_W-1:0]              sr;
    logic [SIZE_W-1:0]              dr;
    logic [MAX_DIMS-1:0][SIZE_W-1:0] sc;
    logic [MAX_DIMS-1:0][SIZE_W-1:0] dc;
  } stg_t;

  // configuration
  logic [CNT_W-1:0]  dim_count;
  logic [SIZE_W-1:0] dim_size [HARD_DIMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count   <= CNT_W'(2);
      dim_size[0] <= SIZE_W'(4);
      dim_size[1] <= SIZE_W'(4);
      dim_size[2] <= SIZE_W'(1);
      dim_size[3] <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_COUNT: dim_count   <= cfg_data[CNT_W-1:0];
        REG_SIZE_DIM0: dim_size[0] <= cfg_data;
        REG_SIZE_DIM1: dim_size[1] <= cfg_data;
        REG_SIZE_DIM2: dim_size[2] <= cfg_data;
        REG_SIZE_DIM3: dim_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] eff [HARD_DIMS];
  logic [CNT_W-1:0]  used;

  always_comb begin
    for (int k = 0; k < HARD_DIMS; k++) begin
      eff[k] = (dim_size[k] == '0) ? SIZE_W'(1) : dim_size[k];
    end
    used = (dim_count > MAX_CNT) ? MAX_CNT : dim_count;
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // divider pipeline: stage s retires quotient bit of dimension s / N
  stg_t pipe [NS];
  logic vld  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = s / N;
    localparam int J = s % N;
    stg_t a;
    stg_t o;

    if (s == 0) begin : g_first
      always_comb begin
        a    = '0;
        a.sx = s_tdata[N-1:0];
        a.dx = s_tdata[2*N-1:N];
      end
    end else if (J == 0) begin : g_next_dim
      always_comb begin
        a          = pipe[s-1];
        a.sc[K-1]  = pipe[s-1].sr;
        a.dc[K-1]  = pipe[s-1].dr;
        a.sr       = '0;
        a.dr       = '0;
      end
    end else begin : g_mid
      assign a = pipe[s-1];
    end

    always_comb begin
      logic [SIZE_W:0] rs;
      logic [SIZE_W:0] rd;
      logic [SIZE_W:0] dv;
      logic            qs;
      logic            qd;
      o  = a;
      dv = {1'b0, eff[K]};
      rs = {a.sr, a.sx[N-1]};
      rd = {a.dr, a.dx[N-1]};
      qs = (rs >= dv);
      qd = (rd >= dv);
      o.sr = qs ? SIZE_W'(rs - dv) : rs[SIZE_W-1:0];
      o.dr = qd ? SIZE_W'(rd - dv) : rd[SIZE_W-1:0];
      o.sx = {a.sx[N-2:0], qs};
      o.dx = {a.dx[N-2:0], qd};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= (s == 0) ? s_tvalid : vld[s-((s == 0) ? 0 : 1)];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[s] <= o;
      end
    end
  end

  // wrap stage
  stg_t              last;
  logic              f1_vld;
  logic [SIZE_W-1:0] f1_diff [HARD_DIMS];

  always_comb begin
    last               = pipe[NS-1];
    last.sc[MAX_DIMS-1] = pipe[NS-1].sr;
    last.dc[MAX_DIMS-1] = pipe[NS-1].dr;
  end

  for (genvar k = 0; k < HARD_DIMS; k++) begin : g_wrap
    logic [SIZE_W:0] t;
    if (k < MAX_DIMS) begin : g_used
      always_comb begin
        t = {1'b0, last.dc[k]} - {1'b0, last.sc[k]};
        if (last.dc[k] < last.sc[k]) begin
          t = t + {1'b0, eff[k]};
        end
      end
    end else begin : g_none
      assign t = '0;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        f1_diff[k] <= t[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= vld[NS-1];
    end
  end

  // direction and output register
  logic [HARD_DIMS*(HOPS_W+1)-1:0] out_next;

  always_comb begin
    logic [SIZE_W-1:0] hp;
    logic              w;
    out_next = '0;
    for (int k = 0; k < HARD_DIMS; k++) begin
      w  = 1'b0;
      hp = f1_diff[k];
      if (f1_diff[k] > {1'b0, eff[k][SIZE_W-1:1]}) begin
        w  = 1'b1;
        hp = eff[k] - f1_diff[k];
      end
      if (CNT_W'(k) < used) begin
        out_next[k*(HOPS_W+1) +: (HOPS_W+1)] = {w, hp[HOPS_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= out_next;
    end
  end

  `TRO_ASSERT(a_west_nonzero, !m_tvalid || !m_tdata[HOPS_W] || (m_tdata[HOPS_W-1:0] != '0), "west with zero hops in dimension zero")
  `TRO_ASSERT_NEXT(a_wrap_to_out, f1_vld && adv, m_tvalid, "wrap stage result lost")
  `TRO_ASSERT_NEXT(a_div_to_wrap, vld[NS-1] && adv, f1_vld, "divider result lost")

endmodule

@@ sim/tb_torus_relative_offset_top.sv @@
`timescale 1ns / 1ps

module tb_torus_relative_offset_top;
  import tro_pkg::*;

  localparam int  DRAIN_CYCLES = 80;
  localparam int  STALL_LIMIT  = 20000;
  localparam int  RAND_PER_PH  = 200;
  // indexes past the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  torus_relative_offset_top dut (.*);

  always #4 clk = ~clk;

  // shadow copy of the registers
  logic [2:0]  dim_cnt;
  logic [7:0]  dim_sz [4];

  logic [31:0] expected_offsets [$];
  int          mismatches = 0;
  int          orphans = 0;
  int          idle_cnt = 0;
  bit          tx_idle = 0;
  bit          rx_stall = 0;
  // percent of idle cycles on each side; lower when both sides idle
  int          idle_pct = 80;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [7:0]  val;
    logic [15:0] src;
    logic [15:0] dst;
    bit          typed;
    logic [31:0] ex;
  } row_t;
  row_t rows [$];

  function automatic logic [31:0] torus_offsets(input logic [15:0] s, input logic [15:0] d);
    longint unsigned w, sz, sc, dc, df;
    int unsigned used;
    logic [31:0] r;
    r = '0;
    w = 1;
    used = (dim_cnt > 4) ? 4 : dim_cnt;
    for (int k = 0; k < 4; k++) begin
      if (k < used) begin
        sz = (dim_sz[k] == 0) ? 1 : dim_sz[k];
        sc = (s / w) % sz;
        dc = (d / w) % sz;
        df = (dc + sz - sc) % sz;
        if (df > sz / 2) begin
          r[8*k +: 7] = 7'(sz - df);
          r[8*k + 7]  = 1'b1;
        end else begin
          r[8*k +: 7] = 7'(df);
        end
        w = w * sz;
      end
    end
    return r;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (expected_offsets.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIM_COUNT) dim_cnt = val[2:0];
    else if (idx >= REG_SIZE_DIM0 && idx <= REG_SIZE_DIM3) dim_sz[idx - 1] = val;
    @(posedge clk);
  endtask

  task automatic push_item(input logic [15:0] s, input logic [15:0] d, input bit typed,
                           input logic [31:0] ex);
    s_tvalid <= 1'b1;
    s_tdata <= {d, s};
    do @(posedge clk); while (!s_tready);
    expected_offsets.insert(expected_offsets.size(), typed ? ex : torus_offsets(s, d));
    if (tx_idle && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  function automatic void add_item(input logic [15:0] s, input logic [15:0] d, input bit typed,
                                   input logic [31:0] ex);
    row_t r;
    r = '{0, '0, '0, s, d, typed, ex};
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [7:0] val);
    row_t r;
    r = '{1, idx, val, '0, '0, 0, '0};
    rows.insert(rows.size(), r);
  endfunction

  always @(posedge clk) begin
    m_tready <= rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_offsets.size() == 0) begin
        orphans++;
        $display("unexpected transaction: %h", m_tdata);
      end else begin
        want = expected_offsets.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (m_tdata[8*k +: 7] !== want[8*k +: 7] || m_tdata[8*k+7] !== want[8*k+7]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("dim %0d: hops exp %0d got %0d, west exp %0b got %0b", k,
                       want[8*k +: 7], m_tdata[8*k +: 7], want[8*k+7], m_tdata[8*k+7]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] sz;
    dim_cnt = 3'd2;
    dim_sz[0] = 8'd4;
    dim_sz[1] = 8'd4;
    dim_sz[2] = 8'd1;
    dim_sz[3] = 8'd1;

    // reset config: 4 x 4
    add_item(16'h0000, 16'h0000, 1, 32'h0000_0000);
    add_item(16'h0000, 16'h0002, 1, 32'h0000_0002); // tie goes east
    add_item(16'h0000, 16'h0003, 1, 32'h0000_0081);
    add_item(16'h0000, 16'h0004, 1, 32'h0000_0100);
    add_item(16'hFFFF, 16'h0000, 1, 32'h0000_0101);
    add_item(16'h0000, 16'hFFFF, 1, 32'h0000_8181);
    add_cfg(REG_DIM_COUNT, 8'd0);
    add_item(16'h1234, 16'h4321, 1, 32'h0000_0000);
    add_cfg(REG_DIM_COUNT, 8'd7);                   // clamps to four
    add_cfg(REG_SIZE_DIM0, 8'd255);
    add_cfg(REG_SIZE_DIM1, 8'd255);
    add_cfg(REG_SIZE_DIM2, 8'd255);
    add_cfg(REG_SIZE_DIM3, 8'd255);
    add_item(16'h0000, 16'h007F, 1, 32'h0000_007F);
    add_item(16'h0000, 16'h0080, 1, 32'h0000_00FF);
    add_item(16'hFFFF, 16'h0000, 0, '0);
    add_cfg(REG_SIZE_DIM1, 8'd0);                   // zero size acts as one
    add_item(16'hABCD, 16'h5432, 0, '0);
    add_cfg(IDX_SPARE5, 8'd0);
    add_cfg(IDX_SPARE6, 8'd0);
    add_cfg(IDX_SPARE7, 8'd0);
    add_item(16'h8001, 16'h7FFE, 0, '0);
    add_cfg(REG_DIM_COUNT, 8'd4);
    add_cfg(REG_SIZE_DIM0, 8'd2);
    add_item(16'h0000, 16'h0001, 1, 32'h0000_0001);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else push_item(rows[i].src, rows[i].dst, rows[i].typed, rows[i].ex);
    end

    for (int ph = 0; ph < 8; ph++) begin
      tx_idle  = (ph % 4 == 1) || (ph % 4 == 3);
      rx_stall = (ph % 4 == 2) || (ph % 4 == 3);
      idle_pct = (tx_idle && rx_stall) ? 38 : 80;
      write_reg(REG_DIM_COUNT, (ph == 7) ? 8'd1 : 8'($urandom_range(7)));
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(5))
          0: sz = 8'd0;
          1: sz = 8'd1;
          2: sz = 8'd255;
          3: sz = 8'($urandom_range(255));
          default: sz = 8'($urandom_range(2, 16));
        endcase
        write_reg(3'(REG_SIZE_DIM0 + k), sz);
      end
      for (int n = 0; n < RAND_PER_PH; n++) begin
        if (ph == 4 && n == RAND_PER_PH / 2) drain();
        push_item(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 0, '0);
      end
    end

    drain();
    if (mismatches == 0 && orphans == 0 && expected_offsets.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
